// ===== sv/quaternion_vector_rotate_unit_assert.svh =====
// Assertion macros shared by the quaternion vector rotate unit.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QVR_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("qvr implication check failed");

// Next-cycle implication, checked outside reset.
`define QVR_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("qvr next-cycle check failed");

`endif

// ===== sv/qvr_pkg.sv =====
// Types and constants of the quaternion vector rotate unit.
`default_nettype none
package qvr_pkg;

   // Pipeline shape: seven arithmetic stages, one stage per quotient bit, round, output.
   localparam int DIV_STEPS  = 32;
   localparam int DIV_FIRST  = 7;
   localparam int NUM_STAGES = DIV_FIRST + DIV_STEPS + 2;

   // Denominator (sum of four squares) and dividend magnitude widths.
   localparam int DEN_W = 65;
   localparam int REM_W = 100;
   localparam int LANES = 3;

   // Per-stage enables and valid bits of the pipeline.
   typedef struct packed {
      logic [NUM_STAGES-1:0] ce;
      logic [NUM_STAGES-1:0] vld;
   } pipe_ctl_type;

   // Data that travels through the division stages.
   typedef struct packed {
      logic [LANES-1:0][REM_W-1:0] rem;
      logic [LANES-1:0][31:0]      quo;
      logic [LANES-1:0]            neg;
      logic [LANES-1:0]            sat;
      logic [DEN_W-1:0]            den;
      logic                        degen;
   } div_type;

endpackage
`default_nettype wire

// ===== sv/qvr_pipe_ctl.sv =====
// Valid bits and bubble-collapsing stage enables of the rotate pipeline.
`default_nettype none
`include "quaternion_vector_rotate_unit_assert.svh"
module qvr_pipe_ctl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   rsp_ready,
   output qvr_pkg::pipe_ctl_type ctl
);

   localparam int NST = qvr_pkg::NUM_STAGES;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST-1:0] ce;

   // A stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      ce[NST-1] = rsp_ready | ~vld_ff[NST-1];
      for (int s = NST - 2; s >= 0; s--) begin
         ce[s] = ce[s+1] | ~vld_ff[s];
      end
   end

   // Valid bits follow the data of each stage.
   always_comb begin
      vld_in[0] = ce[0] ? req_valid : vld_ff[0];
      for (int s = 1; s < NST; s++) begin
         vld_in[s] = ce[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctl.ce  = ce;
   assign ctl.vld = vld_ff;

   // A held beat is never overwritten by the stage in front of it.
   for (genvar g = 0; g < NST - 1; g++) begin : g_chk
      `QVR_ASSERT_IMP(a_no_overwrite, clock, reset, vld_ff[g] && !ce[g+1], !ce[g])
   end
   `QVR_ASSERT_IMP(a_empty_takes, clock, reset, !vld_ff[0], ce[0])
   `QVR_ASSERT_NXT(a_drain, clock, reset,
                   rsp_ready && vld_ff[NST-1] && !vld_ff[NST-2], !vld_ff[NST-1])

endmodule
`default_nettype wire

// ===== sv/qvr_div_stage.sv =====
// One restoring division step for the three lanes, with its stage register.
`default_nettype none
module qvr_div_stage #(
   parameter int STEP = 31
) (
   input  wire                   clock,
   input  wire                   ce,
   input  wire qvr_pkg::div_type stage_in,
   output qvr_pkg::div_type      stage_out
);

   qvr_pkg::div_type stage_ff;
   qvr_pkg::div_type stage_in_d;
   logic [qvr_pkg::REM_W-1:0] den_sh;

   // Try to take the shifted denominator out of each remainder.
   always_comb begin
      den_sh     = qvr_pkg::REM_W'(stage_in.den) << STEP;
      stage_in_d = stage_in;
      for (int k = 0; k < qvr_pkg::LANES; k++) begin
         if (stage_in.rem[k] >= den_sh) begin
            stage_in_d.rem[k]       = stage_in.rem[k] - den_sh;
            stage_in_d.quo[k][STEP] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         stage_ff <= stage_in_d;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

// ===== sv/quaternion_vector_rotate_unit.sv =====
// Top level: rotates a vector by a quaternion and keeps its length.
// Throughput: one beat per cycle; a stalled response holds only the stages that are full.
// The depth is set by the divider, which resolves one quotient bit per stage.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
`include "quaternion_vector_rotate_unit_assert.svh"
module quaternion_vector_rotate_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire signed  [31:0] req_quat_w,
   input  wire signed  [31:0] req_quat_x,
   input  wire signed  [31:0] req_quat_y,
   input  wire signed  [31:0] req_quat_z,
   input  wire signed  [31:0] req_vec_x,
   input  wire signed  [31:0] req_vec_y,
   input  wire signed  [31:0] req_vec_z,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [31:0] rsp_rot_x,
   output logic signed [31:0] rsp_rot_y,
   output logic signed [31:0] rsp_rot_z,
   output logic               rsp_degenerate
);

   localparam int NST   = qvr_pkg::NUM_STAGES;
   localparam int DW    = qvr_pkg::DEN_W;
   localparam int RW    = qvr_pkg::REM_W;
   localparam int FIRST = qvr_pkg::DIV_FIRST;
   localparam logic [32:0] MAX_POS = 33'h0_7FFF_FFFF;
   localparam logic [32:0] MAX_NEG = 33'h0_8000_0000;

   qvr_pkg::pipe_ctl_type ctl;

   qvr_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   assign req_ready = ctl.ce[0];
   assign rsp_valid = ctl.vld[NST-1];

   logic signed [31:0] qv [4];
   logic signed [31:0] vv [3];

   assign qv[0] = req_quat_w;
   assign qv[1] = req_quat_x;
   assign qv[2] = req_quat_y;
   assign qv[3] = req_quat_z;
   assign vv[0] = req_vec_x;
   assign vv[1] = req_vec_y;
   assign vv[2] = req_vec_z;

   // Stage 0: the square, dot-product and cross-product terms, each a 32 by 32 product of the inputs.
   logic signed [63:0] sq_ff [4];
   logic signed [63:0] dp_ff [3];
   logic signed [63:0] cp_ff [3];
   logic signed [63:0] cm_ff [3];
   logic signed [31:0] w0_ff;
   logic signed [31:0] u0_ff [3];
   logic signed [31:0] v0_ff [3];
   logic               dg0_ff;
   logic               dg0_in;

   assign dg0_in = ((req_quat_w | req_quat_x | req_quat_y | req_quat_z) == 32'sd0) ||
                   ((req_vec_x | req_vec_y | req_vec_z) == 32'sd0);

   always_ff @(posedge clock) begin
      if (ctl.ce[0]) begin
         for (int i = 0; i < 4; i++) begin
            sq_ff[i] <= qv[i] * qv[i];
         end
         for (int k = 0; k < 3; k++) begin
            dp_ff[k] <= qv[k+1] * vv[k];
            u0_ff[k] <= qv[k+1];
            v0_ff[k] <= vv[k];
         end
         cp_ff[0] <= req_quat_y * req_vec_z;
         cm_ff[0] <= req_quat_z * req_vec_y;
         cp_ff[1] <= req_quat_z * req_vec_x;
         cm_ff[1] <= req_quat_x * req_vec_z;
         cp_ff[2] <= req_quat_x * req_vec_y;
         cm_ff[2] <= req_quat_y * req_vec_x;
         w0_ff    <= req_quat_w;
         dg0_ff   <= dg0_in;
      end
   end

   // Stage 1: norm, scalar weight, dot product and cross product.
   logic        [DW-1:0] n1_ff;
   logic signed [65:0]   a1_ff;
   logic signed [65:0]   d1_ff;
   logic signed [65:0]   c1_ff [3];
   logic signed [31:0]   w1_ff;
   logic signed [31:0]   u1_ff [3];
   logic signed [31:0]   v1_ff [3];
   logic                 dg1_ff;

   always_ff @(posedge clock) begin
      if (ctl.ce[1]) begin
         n1_ff <= DW'(sq_ff[0]) + DW'(sq_ff[1]) + DW'(sq_ff[2]) + DW'(sq_ff[3]);
         a1_ff <= 66'(sq_ff[0]) - 66'(sq_ff[1]) - 66'(sq_ff[2]) - 66'(sq_ff[3]);
         d1_ff <= 66'(dp_ff[0]) + 66'(dp_ff[1]) + 66'(dp_ff[2]);
         for (int k = 0; k < 3; k++) begin
            c1_ff[k] <= 66'(cp_ff[k]) - 66'(cm_ff[k]);
            u1_ff[k] <= u0_ff[k];
            v1_ff[k] <= v0_ff[k];
         end
         w1_ff  <= w0_ff;
         dg1_ff <= dg0_ff;
      end
   end

   // Stage 2: partial products of the wide factors, split at bit 33.
   logic signed [65:0] fa [3][3];
   logic signed [32:0] fb [3][3];
   logic signed [66:0] pl_ff [3][3];
   logic signed [65:0] ph_ff [3][3];
   logic        [DW-1:0] n2_ff;
   logic                 dg2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fa[k][0] = a1_ff;
         fb[k][0] = 33'(v1_ff[k]);
         fa[k][1] = d1_ff;
         fb[k][1] = $signed({u1_ff[k], 1'b0});
         fa[k][2] = c1_ff[k];
         fb[k][2] = $signed({w1_ff, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ce[2]) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               pl_ff[k][j] <= $signed({1'b0, fa[k][j][32:0]}) * fb[k][j];
               ph_ff[k][j] <= $signed(fa[k][j][65:33]) * fb[k][j];
            end
         end
         n2_ff  <= n1_ff;
         dg2_ff <= dg1_ff;
      end
   end

   // Stage 3: recombine each split product.
   logic signed [RW-1:0] tm_ff [3][3];
   logic        [DW-1:0] n3_ff;
   logic                 dg3_ff;

   always_ff @(posedge clock) begin
      if (ctl.ce[3]) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               tm_ff[k][j] <= (RW'(ph_ff[k][j]) <<< 33) + RW'(pl_ff[k][j]);
            end
         end
         n3_ff  <= n2_ff;
         dg3_ff <= dg2_ff;
      end
   end

   // Stage 4: numerator of each rotated component.
   logic signed [RW-1:0] p4_ff [3];
   logic        [DW-1:0] n4_ff;
   logic                 dg4_ff;

   always_ff @(posedge clock) begin
      if (ctl.ce[4]) begin
         for (int k = 0; k < 3; k++) begin
            p4_ff[k] <= tm_ff[k][0] + tm_ff[k][1] + tm_ff[k][2];
         end
         n4_ff  <= n3_ff;
         dg4_ff <= dg3_ff;
      end
   end

   // Stage 5: sign and magnitude of the numerators.
   logic [RW-1:0] m5_ff [3];
   logic [2:0]    ng5_ff;
   logic [DW-1:0] n5_ff;
   logic          dg5_ff;

   always_ff @(posedge clock) begin
      if (ctl.ce[5]) begin
         for (int k = 0; k < 3; k++) begin
            ng5_ff[k] <= p4_ff[k][RW-1];
            m5_ff[k]  <= p4_ff[k][RW-1] ? RW'(-p4_ff[k]) : RW'(p4_ff[k]);
         end
         n5_ff  <= n4_ff;
         dg5_ff <= dg4_ff;
      end
   end

   // Stage 6: a quotient of 2^32 or more saturates whatever the rounding.
   qvr_pkg::div_type d6_ff;

   always_ff @(posedge clock) begin
      if (ctl.ce[6]) begin
         for (int k = 0; k < 3; k++) begin
            d6_ff.rem[k] <= m5_ff[k];
            d6_ff.quo[k] <= '0;
            d6_ff.neg[k] <= ng5_ff[k];
            d6_ff.sat[k] <= m5_ff[k] >= (RW'(n5_ff) << qvr_pkg::DIV_STEPS);
         end
         d6_ff.den   <= n5_ff;
         d6_ff.degen <= dg5_ff;
      end
   end

   // Division: one quotient bit per stage, most significant first.
   qvr_pkg::div_type div_chain [qvr_pkg::DIV_STEPS+1];

   assign div_chain[0] = d6_ff;

   for (genvar g = 0; g < qvr_pkg::DIV_STEPS; g++) begin : g_div
      qvr_div_stage #(
         .STEP (qvr_pkg::DIV_STEPS - 1 - g)
      ) u_div (
         .clock     (clock),
         .ce        (ctl.ce[FIRST+g]),
         .stage_in  (div_chain[g]),
         .stage_out (div_chain[g+1])
      );
   end

   // Round half away from zero on the magnitude.
   qvr_pkg::div_type dq;
   logic [32:0] qr_ff [3];
   logic [2:0]  ngr_ff;
   logic [2:0]  str_ff;
   logic        dgr_ff;

   assign dq = div_chain[qvr_pkg::DIV_STEPS];

   always_ff @(posedge clock) begin
      if (ctl.ce[NST-2]) begin
         for (int k = 0; k < 3; k++) begin
            qr_ff[k] <= 33'(dq.quo[k]) +
                        33'({dq.rem[k][DW-1:0], 1'b0} >= (DW + 1)'(dq.den));
            ngr_ff[k] <= dq.neg[k];
            str_ff[k] <= dq.sat[k];
         end
         dgr_ff <= dq.degen;
      end
   end

   // Output stage: saturate, apply the sign, force zero when degenerate.
   logic signed [31:0] rot_in [3];
   logic signed [31:0] rot_ff [3];
   logic               dgo_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dgr_ff) begin
            rot_in[k] = '0;
         end else if (!ngr_ff[k]) begin
            rot_in[k] = (str_ff[k] || qr_ff[k] > MAX_POS) ? MAX_POS[31:0] : qr_ff[k][31:0];
         end else begin
            rot_in[k] = (str_ff[k] || qr_ff[k] > MAX_NEG) ? MAX_NEG[31:0] : -qr_ff[k][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ce[NST-1]) begin
         for (int k = 0; k < 3; k++) begin
            rot_ff[k] <= rot_in[k];
         end
         dgo_ff <= dgr_ff;
      end
   end

   assign rsp_rot_x      = rot_ff[0];
   assign rsp_rot_y      = rot_ff[1];
   assign rsp_rot_z      = rot_ff[2];
   assign rsp_degenerate = dgo_ff;

   // A degenerate beat always carries a zero vector.
   `QVR_ASSERT_IMP(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate,
                   rsp_rot_x == 32'sd0 && rsp_rot_y == 32'sd0 && rsp_rot_z == 32'sd0)

endmodule
`default_nettype wire

// ===== verif/quaternion_vector_rotate_unit_test.sv =====
// Self-checking testbench for the quaternion vector rotate unit.
`timescale 1ns / 100ps
`default_nettype none
module quaternion_vector_rotate_unit_test;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [31:0] rot_x;
      logic [31:0] rot_y;
      logic [31:0] rot_z;
      logic        degenerate;
   } rotation_type;

   localparam int PIPE_LATENCY = 41;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_quat_w = '0;
   logic signed [31:0] req_quat_x = '0;
   logic signed [31:0] req_quat_y = '0;
   logic signed [31:0] req_quat_z = '0;
   logic signed [31:0] req_vec_x = '0;
   logic signed [31:0] req_vec_y = '0;
   logic signed [31:0] req_vec_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_rot_x;
   logic signed [31:0] rsp_rot_y;
   logic signed [31:0] rsp_rot_z;
   logic               rsp_degenerate;

   rotation_type rotation_q[$];
   int           mismatch_count = 0;
   int           beats_sent = 0;
   int           beats_checked = 0;
   int           degenerate_seen = 0;
   int           saturated_seen = 0;
   int           hold_off_cycles = 0;
   bit           quiet_mode = 1'b0;

   quaternion_vector_rotate_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_quat_w     (req_quat_w),
      .req_quat_x     (req_quat_x),
      .req_quat_y     (req_quat_y),
      .req_quat_z     (req_quat_z),
      .req_vec_x      (req_vec_x),
      .req_vec_y      (req_vec_y),
      .req_vec_z      (req_vec_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rot_x      (rsp_rot_x),
      .rsp_rot_y      (rsp_rot_y),
      .rsp_rot_z      (rsp_rot_z),
      .rsp_degenerate (rsp_degenerate)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rotated vector: ((w^2 - u.u) v + 2 (u.v) u + 2 w (u x v)) / |q|^2, rounded and saturated.
   function automatic rotation_type rotate_vector(input logic signed [31:0] qw, qx, qy, qz,
                                                  input logic signed [31:0] vx, vy, vz);
      rotation_type res;
      wide_type     w, norm, scal, dotp, num, mag, quo, rem;
      wide_type     vv[3];
      wide_type     uu[3];
      wide_type     cr[3];
      logic [31:0]  comp[3];
      res = '0;
      if ((qw | qx | qy | qz) == 0 || (vx | vy | vz) == 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      w = qw;
      uu[0] = qx; uu[1] = qy; uu[2] = qz;
      vv[0] = vx; vv[1] = vy; vv[2] = vz;
      norm = w * w + uu[0] * uu[0] + uu[1] * uu[1] + uu[2] * uu[2];
      scal = w * w - uu[0] * uu[0] - uu[1] * uu[1] - uu[2] * uu[2];
      dotp = uu[0] * vv[0] + uu[1] * vv[1] + uu[2] * vv[2];
      cr[0] = uu[1] * vv[2] - uu[2] * vv[1];
      cr[1] = uu[2] * vv[0] - uu[0] * vv[2];
      cr[2] = uu[0] * vv[1] - uu[1] * vv[0];
      for (int k = 0; k < 3; k++) begin
         num = scal * vv[k] + 2 * dotp * uu[k] + 2 * w * cr[k];
         mag = (num < 0) ? -num : num;
         quo = mag / norm;
         rem = mag % norm;
         if (2 * rem >= norm) quo = quo + 1;
         if (num >= 0) begin
            comp[k] = (quo > 128'sh7FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
         end else begin
            comp[k] = (quo > 128'sh80000000) ? 32'h80000000 : (32'h0 - quo[31:0]);
         end
      end
      res.rot_x = comp[0];
      res.rot_y = comp[1];
      res.rot_z = comp[2];
      return res;
   endfunction

   // Random signed field with a random magnitude, so small and large values both occur.
   function automatic logic signed [31:0] random_field();
      logic signed [31:0] raw;
      raw = $urandom;
      return raw >>> $urandom_range(0, 31);
   endfunction

   // Sends one request beat, optionally after an idle burst, and records its expected result.
   task automatic send_beat(input logic signed [31:0] qw, qx, qy, qz, vx, vy, vz);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_quat_w <= qw;
      req_quat_x <= qx;
      req_quat_y <= qy;
      req_quat_z <= qz;
      req_vec_x  <= vx;
      req_vec_y  <= vy;
      req_vec_z  <= vz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rotation_q.push_back(rotate_vector(qw, qx, qy, qz, vx, vy, vz));
      beats_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (rotation_q.size() != 0) @(posedge clock);
   endtask

   // Extremes, degenerate inputs, identity and saturating rotations.
   task automatic test_directed();
      localparam logic signed [31:0] ONE_Q = 32'sh1000_0000;
      localparam logic signed [31:0] MAXV  = 32'sh7FFF_FFFF;
      localparam logic signed [31:0] MINV  = 32'sh8000_0000;
      localparam logic signed [31:0] HALF_SQRT2 = 32'sh0B50_F4F0;
      send_beat(0, 0, 0, 0, 32'sh10000, 32'sh20000, 32'sh30000);
      send_beat(ONE_Q, 0, 0, 0, 0, 0, 0);
      send_beat(0, 0, 0, 0, 0, 0, 0);
      send_beat(ONE_Q, 0, 0, 0, 32'sh10000, -32'sh20000, 32'sh30000);
      send_beat(0, ONE_Q, 0, 0, 32'sh10000, 32'sh20000, 32'sh30000);
      send_beat(0, 0, ONE_Q, 0, 32'sh10000, 32'sh20000, 32'sh30000);
      send_beat(0, 0, 0, ONE_Q, 32'sh10000, 32'sh20000, 32'sh30000);
      send_beat(-ONE_Q, 0, 0, 0, 1, -1, 1);
      send_beat(HALF_SQRT2, 0, 0, HALF_SQRT2, 32'sh10000, 0, 0);
      send_beat(HALF_SQRT2, HALF_SQRT2, 0, 0, 0, 32'sh10000, 0);
      // A 45 degree turn of a full-scale vector pushes one component past the range.
      send_beat(32'sh0EC8_35E8, 0, 0, 32'sh061F_78A9, MAXV, MAXV, MAXV);
      send_beat(32'sh0EC8_35E8, 0, 0, 32'sh061F_78A9, MINV, MINV, MINV);
      send_beat(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
      send_beat(MINV, MINV, MINV, MINV, MINV, MINV, MINV);
      send_beat(MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV);
      send_beat(-1, -1, -1, -1, -1, -1, -1);
      send_beat(1, 0, 0, 0, MAXV, MINV, 0);
      send_beat(0, 1, 1, 1, MINV, 0, MAXV);
      send_beat(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1, 2, 3);
      send_beat(3, -7, 11, -13, 32'sh0001_8000, -32'sh0000_8000, 32'sh7FFF_0000);
   endtask

   // Mostly unit-scale rotations of random vectors, with full-range noise and zeroed fields mixed in.
   task automatic test_random(input int count);
      logic signed [31:0] f[7];
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0, 1: for (int k = 0; k < 7; k++) f[k] = $urandom;
            2: begin
               for (int k = 0; k < 7; k++) f[k] = random_field();
               f[$urandom_range(0, 6)] = 0;
               if ($urandom_range(0, 1)) {f[0], f[1], f[2], f[3]} = '0;
               else {f[4], f[5], f[6]} = '0;
            end
            default: begin
               for (int k = 0; k < 4; k++) f[k] = $signed($urandom_range(0, 32'h2000_0000))
                                                  - 32'sh1000_0000;
               for (int k = 4; k < 7; k++) f[k] = random_field();
            end
         endcase
         send_beat(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
      end
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall the input.
   task automatic test_backpressure();
      hold_off_cycles = 120;
      test_random(70);
   endtask

   // The sender pauses until every result is back, then resumes.
   task automatic test_drain_restart();
      wait_for_drain();
      test_random(30);
   endtask

   // Both sides stream without idling to end the run.
   task automatic test_full_rate();
      quiet_mode = 1'b1;
      test_random(50);
   endtask

   // Receiver readiness: random stall bursts, or a counted long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(1, 14) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compares each response beat with the oldest expected rotation.
   always @(posedge clock) begin
      rotation_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rotation_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response beat: %h %h %h %b",
                        rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_degenerate);
         end else begin
            expected = rotation_q.pop_front();
            beats_checked++;
            if (expected.degenerate) degenerate_seen++;
            if (expected.rot_x inside {32'h7FFFFFFF, 32'h80000000}) saturated_seen++;
            if (rsp_rot_x !== expected.rot_x || rsp_rot_y !== expected.rot_y ||
                rsp_rot_z !== expected.rot_z || rsp_degenerate !== expected.degenerate) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                           expected.rot_x, expected.rot_y, expected.rot_z,
                           expected.degenerate, rsp_rot_x, rsp_rot_y, rsp_rot_z,
                           rsp_degenerate);
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("quaternion_vector_rotate_unit regression: fail");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(470);
      test_backpressure();
      test_drain_restart();
      test_full_rate();
      wait_for_drain();
      repeat (PIPE_LATENCY + 20) @(posedge clock);
      if (rotation_q.size() != 0) mismatch_count++;
      $display("Checked %0d of %0d rotations: %0d degenerate, %0d with a saturated x.",
               beats_checked, beats_sent, degenerate_seen, saturated_seen);
      $display("Covered extremes, zero inputs, long back-pressure, drain and full rate.");
      if (mismatch_count == 0) begin
         $display("quaternion_vector_rotate_unit regression: pass");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("quaternion_vector_rotate_unit regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
